// ===== design/gbs_pkg.sv =====
// Shared constants, command and status types, and the Gaussian weight table of the bin smoother.
package gbs_pkg;

    localparam int FRAME_LEN  = 256;
    localparam int HALF_TAPS  = 32;
    localparam int WIN_LEN    = 2 * HALF_TAPS - 1;

    localparam int SAMPLE_W   = 16;
    localparam int WEIGHT_W   = 16;
    localparam int FRAC_W     = 16;
    localparam int IDX_W      = 8;
    localparam int OUT_DATA_W = SAMPLE_W + IDX_W;

    localparam int TAP_W      = (HALF_TAPS > 1) ? $clog2(HALF_TAPS) : 1;
    localparam int CNT_W      = $clog2(FRAME_LEN);
    localparam int PAIR_W     = SAMPLE_W + 1;
    localparam int PROD_W     = PAIR_W + WEIGHT_W;
    localparam int ACC_W      = PROD_W + TAP_W;
    localparam int ROM_IDX_W  = 6;

    localparam logic [ACC_W:0] ROUND_HALF = (ACC_W + 1)'(1) << (FRAC_W - 1);

    typedef logic [SAMPLE_W-1:0] sample_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             fill;        // Load every window entry with the incoming sample.
        logic             shift_in;    // Shift the incoming sample into the window.
        logic             shift_last;  // Shift the newest sample in again (right clamp).
        logic             mac_en;      // One multiply step of the weighted sum.
        logic             mac_first;   // The step is the center tap.
        logic [TAP_W-1:0] tap;         // Tap offset of this step.
        logic             write;       // Load the output register with the rounded sum.
        logic [CNT_W-1:0] bin;         // Bin number of the result being written.
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;                // The output register can take a new item.
    } dp_status_t;

    // Q0.16 Gaussian weights, sigma 3.5; offsets of 16 and beyond round to zero.
    function automatic logic [WEIGHT_W-1:0] gauss_weight(input logic [ROM_IDX_W-1:0] j);
        logic [WEIGHT_W-1:0] w;
        unique case (j)
            6'd0:    w = 16'd7470;
            6'd1:    w = 16'd7171;
            6'd2:    w = 16'd6345;
            6'd3:    w = 16'd5174;
            6'd4:    w = 16'd3888;
            6'd5:    w = 16'd2693;
            6'd6:    w = 16'd1719;
            6'd7:    w = 16'd1011;
            6'd8:    w = 16'd548;
            6'd9:    w = 16'd274;
            6'd10:   w = 16'd126;
            6'd11:   w = 16'd54;
            6'd12:   w = 16'd21;
            6'd13:   w = 16'd8;
            6'd14:   w = 16'd3;
            6'd15:   w = 16'd1;
            default: w = 16'd0;
        endcase
        return w;
    endfunction

endpackage

// ===== design/gaussian_bin_smoother_unit.sv =====
// Top level of the Gaussian bin smoother: controller, datapath and a few checks.
//
//  Channel  Direction  Signals                       Content of one item
//  s_*      in         s_tvalid s_tready s_tdata     bin_value, next bin of the frame
//  m_*      out        m_tvalid m_tready m_tdata     smoothed value and its bin index
//                      m_tlast                       frame_end, set on the frame's last bin
//
// A bin that causes a result runs through the accept cycle, HALF_TAPS multiply steps on the
// single 17x16 multiplier (the center tap, then one folded tap pair per cycle), a drain step
// to add the last product and a write step to round, saturate and load the output register
// before the next bin can be taken. Bins before the first result only enter the window.
// The last bin of a frame is followed by HALF_TAPS-1 flush results; the repeated last bin
// is shifted in during the write cycle of the result before it.
// Reset clears the controller, the frame position and the output valid flag.
// A stalled output holds the machine in its write cycle; earlier results are kept intact.
// While the sum is computed, s_tready stays low.
module gaussian_bin_smoother_unit
    import gbs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [SAMPLE_W-1:0]   s_tdata,   // [15:0] bin_value
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [15:0] smoothed, [23:16] bin_index
    output logic                  m_tlast    // frame_end
);

    dp_cmd_t    cmd;
    dp_status_t status;

    gbs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    gbs_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_value (s_tdata),
        .cmd      (cmd),
        .status   (status),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // A result is never written over one that is still waiting at the output.
    assert property (@(posedge clk) disable iff (!rst_n) cmd.write |-> status.out_free)
        else $error("result written while output register is occupied");

    // No new bin is taken while the weighted sum is being computed.
    assert property (@(posedge clk) disable iff (!rst_n) cmd.mac_en |-> !s_tready)
        else $error("input ready during multiply-accumulate");

    // The frame end marker belongs to the last bin of the frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> (m_tdata[OUT_DATA_W-1:SAMPLE_W] == IDX_W'(FRAME_LEN - 1)))
        else $error("frame end flagged on a bin other than the last");

    // A write always follows a complete sum: the cycle before it adds no new step.
    assert property (@(posedge clk) disable iff (!rst_n) cmd.write |-> !$past(cmd.mac_en))
        else $error("result written before the sum was complete");

endmodule

// ===== design/gbs_ctrl.sv =====
// Controller of the bin smoother: frame position, tap sequencing and flush of the frame tail.
module gbs_ctrl
    import gbs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_MAC   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_WRITE = 2'd3;

    localparam logic [CNT_W-1:0] FIRST_OUT = CNT_W'(HALF_TAPS - 1);
    localparam logic [CNT_W-1:0] LAST_BIN  = CNT_W'(FRAME_LEN - 1);
    localparam logic [TAP_W-1:0] LAST_TAP  = TAP_W'(HALF_TAPS - 1);

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] out_bin_reg, out_bin_next;
    logic [TAP_W-1:0] tap_reg, tap_next;
    logic             accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_ready && in_valid;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        out_bin_next   = out_bin_reg;
        tap_next       = tap_reg;
        cmd            = '0;
        cmd.tap        = tap_reg;
        cmd.bin        = out_bin_reg;
        cmd.mac_first  = (tap_reg == '0);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.fill     = (count_reg == '0);
                    cmd.shift_in = (count_reg != '0);
                    count_next   = (count_reg == LAST_BIN) ? '0 : count_reg + 1'b1;
                    if (count_reg >= FIRST_OUT)
                    begin
                        out_bin_next = count_reg - FIRST_OUT;
                        tap_next     = '0;
                        state_next   = ST_MAC;
                    end
                end
            end
            ST_MAC:
            begin
                cmd.mac_en = 1'b1;
                if (tap_reg == LAST_TAP)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    tap_next = tap_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (status.out_free)
                begin
                    cmd.write = 1'b1;
                    // A zero frame position here means the last bin came in: keep flushing.
                    if (count_reg == '0 && out_bin_reg != LAST_BIN)
                    begin
                        cmd.shift_last = 1'b1;
                        out_bin_next   = out_bin_reg + 1'b1;
                        tap_next       = '0;
                        state_next     = ST_MAC;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            out_bin_reg <= '0;
            tap_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            out_bin_reg <= out_bin_next;
            tap_reg     <= tap_next;
        end
    end

endmodule

// ===== design/gbs_datapath.sv =====
// Datapath of the bin smoother: sample window, folded multiply-accumulate and output register.
module gbs_datapath
    import gbs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  sample_t               in_value,
    input  dp_cmd_t               cmd,
    output dp_status_t            status,
    input  logic                  m_tready,
    output logic                  m_tvalid,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tlast
);

    sample_t               win_reg  [WIN_LEN];
    sample_t               win_next [WIN_LEN];
    sample_t               shift_val;

    logic [PAIR_W-1:0]     pair;
    logic [PAIR_W-1:0]     operand;
    logic [WEIGHT_W-1:0]   weight;
    logic [PROD_W-1:0]     prod_reg, prod_next;
    logic                  pvalid_reg;
    logic                  pfirst_reg;
    logic [ACC_W-1:0]      acc_reg, acc_next;

    logic [ACC_W:0]        rounded;
    logic [ACC_W-FRAC_W:0] scaled;
    sample_t               result;

    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic                  out_last_reg;

    assign shift_val = cmd.shift_in ? in_value : win_reg[WIN_LEN-1];

    // The two halves rotate during the sum so the tap pair is always read at the
    // entries beside the center; after HALF_TAPS-1 rotations they are back in place.
    always_comb
    begin
        win_next = win_reg;
        if (cmd.fill)
        begin
            for (int i = 0; i < WIN_LEN; i++)
            begin
                win_next[i] = in_value;
            end
        end
        else if (cmd.shift_in || cmd.shift_last)
        begin
            for (int i = 0; i < WIN_LEN - 1; i++)
            begin
                win_next[i] = win_reg[i+1];
            end
            win_next[WIN_LEN-1] = shift_val;
        end
        else if (cmd.mac_en && !cmd.mac_first)
        begin
            win_next[0] = win_reg[HALF_TAPS-2];
            for (int i = 1; i < HALF_TAPS - 1; i++)
            begin
                win_next[i] = win_reg[i-1];
            end
            for (int i = HALF_TAPS; i < WIN_LEN - 1; i++)
            begin
                win_next[i] = win_reg[i+1];
            end
            win_next[WIN_LEN-1] = win_reg[HALF_TAPS];
        end
    end

    assign pair    = {1'b0, win_reg[HALF_TAPS-2]} + {1'b0, win_reg[HALF_TAPS]};
    assign operand = cmd.mac_first ? {1'b0, win_reg[HALF_TAPS-1]} : pair;
    assign weight  = gauss_weight(ROM_IDX_W'(cmd.tap));

    assign prod_next = PROD_W'(operand) * PROD_W'(weight);

    always_comb
    begin
        acc_next = acc_reg;
        if (pvalid_reg)
        begin
            acc_next = pfirst_reg ? ACC_W'(prod_reg) : acc_reg + ACC_W'(prod_reg);
        end
    end

    assign rounded = {1'b0, acc_reg} + ROUND_HALF;
    assign scaled  = rounded[ACC_W:FRAC_W];
    assign result  = (|scaled[ACC_W-FRAC_W:SAMPLE_W]) ? {SAMPLE_W{1'b1}} : scaled[SAMPLE_W-1:0];

    assign status.out_free = !out_valid_reg || m_tready;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < WIN_LEN; i++)
        begin
            win_reg[i] <= win_next[i];
        end
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        if (cmd.write)
        begin
            out_data_reg <= {IDX_W'(cmd.bin), result};
            out_last_reg <= (cmd.bin == CNT_W'(FRAME_LEN - 1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pvalid_reg    <= 1'b0;
            pfirst_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pvalid_reg <= cmd.mac_en;
            pfirst_reg <= cmd.mac_first;
            if (cmd.write)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule
